FILE: hw/rtl/sumd_pkg.sv
`timescale 1ns / 1ps

package sumd_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int IDX_W         = 6;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]       HDR_ID     = 8'hA8;
  localparam logic [7:0]       HDR_TYPE   = 8'h01;
  localparam logic [7:0]       HDR_COUNT  = 8'(CHANNEL_COUNT);
  localparam logic [15:0]      CRC_POLY   = 16'h1021;
  localparam logic [15:0]      CH_CENTER  = 16'd12000;
  localparam logic [15:0]      CH_MIN     = 16'h1c20;
  localparam logic [15:0]      CH_MAX     = 16'h41a0;
  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(CHANNEL_COUNT - 1);

  typedef struct packed {
    logic [15:0] word;
    logic        first;
    logic        last;
  } entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/sumd_frame_encoder_unit.sv
`timescale 1ns / 1ps
// servo frame encoder
// input channel: channel_value with in_valid / in_ready, one word per channel,
//   channels in order, CHANNEL_COUNT words make one frame
// output channel: frame_byte, end_of_frame, end_of_run with out_valid / out_ready
// each input word yields its channel high and low byte, preceded by the three
//   header bytes on the first channel and followed by the crc high and low byte
//   on the last channel, so 2 to 5 output words per input word
// end_of_run marks the last output word of an input word, end_of_frame the crc low byte
// an input word passes the queue, the emitter's entry register and the output register before its first output word
//   is valid; throughput: the byte emitter sends one byte per cycle while the receiver does not stall,
//   and a two-entry queue lets the input side run ahead of the emitter
// reset clears the channel index, crc, queue and output valid flag; the next word
//   starts a new frame
// when the receiver stalls the output word holds, the emitter waits and the
//   input side keeps taking words until the queue is full
module sumd_frame_encoder_unit import sumd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [11:0] channel_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         frame_byte,
  output logic               end_of_frame,
  output logic               end_of_run
);

  entry_t push_data;
  entry_t pop_data;
  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_valid;

  sumd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .channel_value (channel_value),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (push_data)
  );

  sumd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (pop_data)
  );

  sumd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .end_of_frame (end_of_frame),
    .end_of_run   (end_of_run)
  );

endmodule

FILE: hw/rtl/sumd_front.sv
`timescale 1ns / 1ps

module sumd_front import sumd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [11:0] channel_value,
  input  logic               q_full,
  output logic               q_push,
  output entry_t             q_data
);

  logic [IDX_W-1:0] index;
  logic [IDX_W-1:0] index_next;
  logic [15:0]      scaled;
  logic [15:0]      word;
  logic             last;

  always_comb begin
    scaled = {{2{channel_value[11]}}, channel_value, 2'b00} + CH_CENTER;
    if (scaled < CH_MIN) begin
      word = CH_MIN;
    end else if (scaled > CH_MAX) begin
      word = CH_MAX;
    end else begin
      word = scaled;
    end
    last       = (index >= LAST_INDEX);
    index_next = last ? '0 : index + 1'b1;
  end

  assign in_ready     = !q_full;
  assign q_push       = in_valid && in_ready;
  assign q_data.word  = word;
  assign q_data.first = (index == '0);
  assign q_data.last  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      index <= '0;
    end else if (q_push) begin
      index <= index_next;
    end
  end

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    index <= LAST_INDEX)
    else $error("channel index past last channel");

endmodule

FILE: hw/rtl/sumd_fifo.sv
`timescale 1ns / 1ps

module sumd_fifo import sumd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   pop_valid,
  output entry_t pop_data
);

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("queue pop while empty");

endmodule

FILE: hw/rtl/sumd_back.sv
`timescale 1ns / 1ps

module sumd_back import sumd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  entry_t     q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] frame_byte,
  output logic       end_of_frame,
  output logic       end_of_run
);

  typedef enum logic [2:0] {
    ST_ID, ST_TYPE, ST_COUNT, ST_HI, ST_LO, ST_CRC_HI, ST_CRC_LO
  } step_t;

  step_t       step;
  step_t       step_next;
  entry_t      entry;
  logic        busy;
  logic [15:0] crc;
  logic [15:0] crc_in;
  logic [7:0]  byte_val;
  logic        load;
  logic        emit;
  logic        done_now;
  logic        crc_step;

  always_comb begin
    crc_in    = (step == ST_ID) ? 16'h0000 : crc;
    byte_val  = 8'h00;
    step_next = step;
    crc_step  = 1'b1;
    case (step)
      ST_ID: begin
        byte_val  = HDR_ID;
        step_next = ST_TYPE;
      end
      ST_TYPE: begin
        byte_val  = HDR_TYPE;
        step_next = ST_COUNT;
      end
      ST_COUNT: begin
        byte_val  = HDR_COUNT;
        step_next = ST_HI;
      end
      ST_HI: begin
        byte_val  = entry.word[15:8];
        step_next = ST_LO;
      end
      ST_LO: begin
        byte_val  = entry.word[7:0];
        step_next = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        byte_val  = crc[15:8];
        step_next = ST_CRC_LO;
        crc_step  = 1'b0;
      end
      ST_CRC_LO: begin
        byte_val  = crc[7:0];
        step_next = ST_ID;
        crc_step  = 1'b0;
      end
      default: begin
        byte_val  = 8'h00;
        step_next = ST_ID;
        crc_step  = 1'b0;
      end
    endcase
    load     = !out_valid || out_ready;
    emit     = busy && load;
    done_now = ((step == ST_LO) && !entry.last) || (step == ST_CRC_LO);
    q_pop    = q_valid && (!busy || (emit && done_now));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      step      <= ST_ID;
      crc       <= '0;
    end else begin
      if (load) begin
        out_valid <= emit;
      end
      if (emit) begin
        frame_byte   <= byte_val;
        end_of_frame <= (step == ST_CRC_LO);
        end_of_run   <= done_now;
        if (crc_step) begin
          crc <= crc_byte(crc_in, byte_val);
        end
      end
      if (q_pop) begin
        entry <= q_data;
        step  <= q_data.first ? ST_ID : ST_HI;
        busy  <= 1'b1;
      end else if (emit) begin
        step <= step_next;
        if (done_now) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_eof_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> end_of_run)
    else $error("frame end without end of word");

  a_header_only_first: assert property (@(posedge clk) disable iff (rst)
    busy && (step == ST_TYPE || step == ST_COUNT) |-> entry.first)
    else $error("header bytes on a word that does not open a frame");

  a_crc_only_last: assert property (@(posedge clk) disable iff (rst)
    busy && (step == ST_CRC_HI || step == ST_CRC_LO) |-> entry.last)
    else $error("crc bytes on a word that does not close a frame");

endmodule
